@@ sv/id_pair_hash_map_defines.svh @@
// ----------------------------------------------------------------------------
// id_pair_hash_map_defines : assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ID_PAIR_HASH_MAP_DEFINES_SVH
`define ID_PAIR_HASH_MAP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define IPHM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("id_pair_hash_map assertion failed");
// Checked at every edge, reset included.
`define IPHM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("id_pair_hash_map assertion failed");
`else
`define IPHM_ASSERT(name, clk, rst_n, prop)
`define IPHM_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ sv/iphm_pkg.sv @@
// ----------------------------------------------------------------------------
// iphm_pkg : shared types and codes
// Command and result payloads, function and status codes, sequencer states.
// ----------------------------------------------------------------------------
package iphm_pkg;

  localparam int ID_W  = 15;
  localparam int MOD_W = 10;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 10'd23;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_S2C    = 2'd1;
  localparam logic [1:0] FN_C2S    = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_OVERFLOW  = 2'd2;
  localparam logic [1:0] STS_FULL      = 2'd3;

  localparam logic REG_USER_MOD  = 1'b0;
  localparam logic REG_GROUP_MOD = 1'b1;

  typedef struct packed {
    logic [1:0]        func;
    logic              map_select;
    logic signed [15:0] lookup_id;
    logic [ID_W-1:0]   insert_server_id;
    logic [ID_W-1:0]   insert_client_id;
  } iphm_cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] mapped_id;
  } iphm_res_t;

  typedef struct packed {
    logic [ID_W-1:0]  dividend;
    logic [MOD_W-1:0] divisor;
  } iphm_div_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_DIV,
    S_PROBE,
    S_SLOT,
    S_PAIR,
    S_WR_PAIR,
    S_WR_S,
    S_WR_C
  } iphm_state_e;

endpackage

@@ sv/id_pair_hash_map.sv @@
// ----------------------------------------------------------------------------
// id_pair_hash_map : user/group id translation with hashed index tables
// Flow: a command rejected at accept is answered from idle; else each hash
//   runs a start step and the remainder unit, each probed slot a read and a
//   check, each lookup candidate a key compare, and an insert ends in 3 writes.
// Throughput: one item at a time; busy drops with the result strobe.
// Reset: control clears at once, then a clearing pass empties the index tables
//   with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "id_pair_hash_map_defines.svh"

module id_pair_hash_map
  import iphm_pkg::*;
#(
  parameter int MAX_PAIRS       = 256,
  parameter int PROBE_SLOP      = 4,
  parameter int SLOTS_PER_TABLE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  iphm_cmd_t   cmd_i,
  // result channel
  output logic        done_o,
  output iphm_res_t   res_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Widths derived from the parameters
  localparam int PAIR_AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CNT_W   = $clog2(MAX_PAIRS + 1);
  localparam int SLOT_AW = $clog2(SLOTS_PER_TABLE);
  localparam int SLOT_MW = SLOT_AW + 2;            // map, side, slot
  localparam int SLOT_CW = $clog2(SLOTS_PER_TABLE + 1);
  localparam int JW      = (SLOT_CW > MOD_W + 1) ? SLOT_CW : MOD_W + 1;
  localparam int PAIR_W  = 2 * ID_W;

  // --------------------------------------------------------------------------
  // Register port: two modulus registers, word addressed by paddr[2]
  // --------------------------------------------------------------------------
  logic [MOD_W-1:0] user_mod_q, group_mod_q;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_mod_q  <= MODULUS_RESET;
      group_mod_q <= MODULUS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_USER_MOD:  user_mod_q  <= pwdata[MOD_W-1:0];
        REG_GROUP_MOD: group_mod_q <= pwdata[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_USER_MOD:  prdata = {{(32-MOD_W){1'b0}}, user_mod_q};
      REG_GROUP_MOD: prdata = {{(32-MOD_W){1'b0}}, group_mod_q};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  iphm_state_e      state_q, state_d;
  iphm_cmd_t        item_q, item_d;
  logic             side_q, side_d;      // 0 server-keyed table, 1 client-keyed
  logic [MOD_W-1:0] mod_q, mod_d;
  logic [JW-1:0]    end_q, end_d;
  logic [JW-1:0]    j_q, j_d;
  logic [JW-1:0]    js_q, js_d;          // free slot found in the server table
  logic [CNT_W-1:0] ucnt_q, ucnt_d;
  logic [CNT_W-1:0] gcnt_q, gcnt_d;
  logic [SLOT_MW-1:0] clr_q, clr_d;
  logic             done_q, done_d;
  iphm_res_t        res_q, res_d;

  // memory ports
  logic               slot_we;
  logic [SLOT_MW-1:0] slot_waddr, slot_raddr;
  logic [CNT_W-1:0]   slot_wdata, slot_rdata;
  logic               pair_we;
  logic [PAIR_AW:0]   pair_waddr, pair_raddr;
  logic [PAIR_W-1:0]  pair_wdata, pair_rdata;

  // remainder unit
  logic             div_start, div_done;
  iphm_div_req_t    div_req;
  logic [MOD_W-1:0] div_rem;

  // helpers
  logic [CNT_W-1:0] cnt_sel, cnt_in;
  logic [MOD_W-1:0] mod_in;
  logic [JW-1:0]    end_in;
  logic [CNT_W-1:0] slot_idx;
  logic [ID_W-1:0]  pair_key, pair_partner;
  logic             is_insert;

  assign cnt_sel   = item_q.map_select ? gcnt_q : ucnt_q;
  assign cnt_in    = cmd_i.map_select ? gcnt_q : ucnt_q;
  assign is_insert = (item_q.func == FN_INSERT);
  assign slot_idx  = slot_rdata - 1'b1;

  // zero modulus acts as one; the probe stops at modulus + slop or the table end
  always_comb begin
    mod_in = cmd_i.map_select ? group_mod_q : user_mod_q;
    if (mod_in == '0) begin
      mod_in = MOD_W'(1);
    end
    end_in = JW'(mod_in) + JW'(PROBE_SLOP);
    if (end_in > JW'(SLOTS_PER_TABLE)) begin
      end_in = JW'(SLOTS_PER_TABLE);
    end
  end

  assign pair_key     = side_q ? pair_rdata[ID_W-1:0] : pair_rdata[PAIR_W-1:ID_W];
  assign pair_partner = side_q ? pair_rdata[PAIR_W-1:ID_W] : pair_rdata[ID_W-1:0];

  assign div_req.dividend = !is_insert ? item_q.lookup_id[ID_W-1:0] :
                            side_q     ? item_q.insert_client_id :
                                         item_q.insert_server_id;
  assign div_req.divisor  = mod_q;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    side_d     = side_q;
    mod_d      = mod_q;
    end_d      = end_q;
    j_d        = j_q;
    js_d       = js_q;
    ucnt_d     = ucnt_q;
    gcnt_d     = gcnt_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    res_d      = res_q;
    div_start  = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = {item_q.map_select, side_q, j_q[SLOT_AW-1:0]};
    slot_wdata = cnt_sel + 1'b1;
    slot_raddr = {item_q.map_select, side_q, j_q[SLOT_AW-1:0]};
    pair_we    = 1'b0;
    pair_waddr = {item_q.map_select, cnt_sel[PAIR_AW-1:0]};
    pair_wdata = {item_q.insert_server_id, item_q.insert_client_id};
    pair_raddr = {item_q.map_select, slot_idx[PAIR_AW-1:0]};

    unique case (state_q)
      S_CLEAR: begin
        // empty one index slot per cycle
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          item_d = cmd_i;
          mod_d  = mod_in;
          end_d  = end_in;
          side_d = (cmd_i.func == FN_C2S);
          case (cmd_i.func) inside
            FN_INSERT: begin
              if (cnt_in >= CNT_W'(MAX_PAIRS)) begin
                done_d = 1'b1;
                res_d  = '{status: STS_FULL, mapped_id: '0};
              end else begin
                state_d = S_START;
              end
            end
            FN_S2C, FN_C2S: begin
              if (cmd_i.lookup_id[15]) begin
                done_d = 1'b1;
                res_d  = '{status: STS_NOT_FOUND, mapped_id: '0};
              end else begin
                state_d = S_START;
              end
            end
            default: begin
              done_d = 1'b1;
              res_d  = '{status: STS_NOT_FOUND, mapped_id: '0};
            end
          endcase
        end
      end

      S_START: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          j_d     = JW'(div_rem);
          state_d = S_PROBE;
        end
      end

      S_PROBE: begin
        // slot read issues from j_q; data arrives in S_SLOT
        if (j_q >= end_q) begin
          done_d  = 1'b1;
          res_d   = '{status: is_insert ? STS_OVERFLOW : STS_NOT_FOUND, mapped_id: '0};
          state_d = S_IDLE;
        end else begin
          state_d = S_SLOT;
        end
      end

      S_SLOT: begin
        if (slot_rdata == '0) begin
          if (!is_insert) begin
            done_d  = 1'b1;
            res_d   = '{status: STS_NOT_FOUND, mapped_id: '0};
            state_d = S_IDLE;
          end else if (!side_q) begin
            // server slot found, hash the client id next
            js_d    = j_q;
            side_d  = 1'b1;
            state_d = S_START;
          end else begin
            state_d = S_WR_PAIR;
          end
        end else if (is_insert) begin
          j_d     = j_q + 1'b1;
          state_d = S_PROBE;
        end else begin
          state_d = S_PAIR;
        end
      end

      S_PAIR: begin
        if (pair_key == item_q.lookup_id[ID_W-1:0]) begin
          done_d  = 1'b1;
          res_d   = '{status: STS_OK, mapped_id: pair_partner};
          state_d = S_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_PROBE;
        end
      end

      S_WR_PAIR: begin
        pair_we = 1'b1;
        state_d = S_WR_S;
      end

      S_WR_S: begin
        slot_we    = 1'b1;
        slot_waddr = {item_q.map_select, 1'b0, js_q[SLOT_AW-1:0]};
        state_d    = S_WR_C;
      end

      S_WR_C: begin
        slot_we = 1'b1;
        if (item_q.map_select) begin
          gcnt_d = gcnt_q + 1'b1;
        end else begin
          ucnt_d = ucnt_q + 1'b1;
        end
        done_d  = 1'b1;
        res_d   = '{status: STS_OK, mapped_id: '0};
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ucnt_q  <= '0;
      gcnt_q  <= '0;
      done_q  <= 1'b0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ucnt_q  <= ucnt_d;
      gcnt_q  <= gcnt_d;
      done_q  <= done_d;
      side_q  <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    mod_q  <= mod_d;
    end_q  <= end_d;
    j_q    <= j_d;
    js_q   <= js_d;
    res_q  <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // --------------------------------------------------------------------------
  // Units
  // --------------------------------------------------------------------------
  iphm_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // four index tables: user/group by server/client id
  iphm_ram #(
    .WIDTH (CNT_W),
    .DEPTH (4 << SLOT_AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // pair store, one half per map
  iphm_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (2 << PAIR_AW)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pair_we),
    .waddr_i (pair_waddr),
    .wdata_i (pair_wdata),
    .raddr_i (pair_raddr),
    .rdata_o (pair_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `IPHM_ASSERT(a_done_when_idle, clk_i, rst_ni, done_o |-> !busy)
  `IPHM_ASSERT(a_ucnt_bound, clk_i, rst_ni, ucnt_q <= CNT_W'(MAX_PAIRS))
  `IPHM_ASSERT(a_probe_in_range, clk_i, rst_ni, (state_q == S_SLOT) |-> (j_q < end_q))
  `IPHM_ASSERT(a_slot_write_nonzero, clk_i, rst_ni,
               (slot_we && state_q != S_CLEAR) |-> (slot_wdata != '0))
  `IPHM_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !done_o)

endmodule

@@ sv/iphm_ram.sv @@
// ----------------------------------------------------------------------------
// iphm_ram : generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/iphm_mod.sv @@
// ----------------------------------------------------------------------------
// iphm_mod : bit-serial remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module iphm_mod
  import iphm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  iphm_div_req_t    req_i,
  output logic             done_o,
  output logic [MOD_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(ID_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ID_W-1:0]  dvd_q, dvd_d;
  logic [MOD_W-1:0] dvs_q, dvs_d;
  logic [MOD_W-1:0] rem_q, rem_d;
  logic [MOD_W:0]   shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    shifted = {rem_q, dvd_q[ID_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // subtract when the shifted partial remainder reaches the divisor
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = MOD_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_d = shifted[MOD_W-1:0];
      end
      dvd_d = {dvd_q[ID_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ID_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
